FILE: src/run_length_escape_line_encoder_macros.svh
// assertion macros for the run length escape line encoder
// used by the front, queue and back modules; needs nothing else
`ifndef RUN_LENGTH_ESCAPE_LINE_ENCODER_MACROS_SVH
`define RUN_LENGTH_ESCAPE_LINE_ENCODER_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define RLEL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define RLEL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/rlel_pkg.sv
// shared types, constants and byte coding functions of the line encoder
// no dependencies; used by the front, queue, back and top level files
package rlel_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [5:0] MAX_RUN = 6'd63;
	localparam logic [7:0] CR_BYTE = 8'h0D;

	// configuration register indexes
	localparam logic [1:0] CFG_BUFFERED = 2'd0;
	localparam logic [1:0] CFG_LIMIT    = 2'd1;
	localparam logic [1:0] CFG_MARKER   = 2'd2;

	localparam logic [6:0] LIMIT_RESET  = 7'd60;
	localparam logic [7:0] MARKER_RESET = 8'h60;

	typedef struct packed {
		logic       buffered;
		logic [6:0] line_limit;
		logic [7:0] marker;
	} cfg_t;

	// one queued unit group: a run, or one to three single copies of a byte
	typedef struct packed {
		logic [7:0] b;
		logic [5:0] cnt;
		logic       run;
		logic       fin;
	} cmd_t;

	localparam logic [7:0] PREFIX_TAB [4] = '{8'h40, 8'h23, 8'h24, 8'h7E};

	function automatic logic [7:0] six_code(input logic [5:0] v);
		six_code = (v[5:4] == 2'b11) ? {2'b00, v} : {2'b01, v};
	endfunction

	function automatic logic is_plain(input logic [7:0] c, input logic [7:0] marker);
		is_plain = (c >= 8'h20) && (c <= 8'h7E) && (c != marker) &&
			(c != 8'h40) && (c != 8'h23) && (c != 8'h24) && (c != 8'h7E);
	endfunction

	function automatic logic [6:0] len_add(input logic [6:0] len, input logic [1:0] d);
		logic [7:0] s;
		s = {1'b0, len} + {6'd0, d};
		len_add = s[7] ? 7'h7F : s[6:0];
	endfunction

endpackage

FILE: src/rlel_in_if.sv
// raw byte channel of the line encoder, valid/ready handshake
// depends on nothing
interface rlel_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source(output valid, output in_byte, output in_last, input ready);
	modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

FILE: src/rlel_out_if.sv
// encoded byte channel of the line encoder, valid/ready handshake
// depends on nothing
interface rlel_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source(output valid, output out_byte, output out_last, input ready);
	modport sink(input valid, input out_byte, input out_last, output ready);
endinterface

FILE: src/rlel_front.sv
// front end: tracks the pending run and turns input beats into queue commands
// depends on rlel_pkg, rlel_in_if and the assertion macro header
`include "run_length_escape_line_encoder_macros.svh"

module rlel_front (
	input  logic            clk,
	input  logic            arst_n,
	rlel_in_if.sink         in_ch,
	input  logic            full,
	output logic            push,
	output rlel_pkg::cmd_t  push_cmd
);

	logic [7:0]     held_byte_q;
	logic [5:0]     held_cnt_q;
	logic           pend_v_q;
	rlel_pkg::cmd_t pend_q;

	logic           accept;
	logic           match;
	logic [5:0]     cnt1;
	logic           a_v;
	logic           b_v;
	rlel_pkg::cmd_t a_cmd;
	rlel_pkg::cmd_t b_cmd;
	logic [5:0]     cnt_d;

	assign in_ch.ready = !pend_v_q && !full;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		match = (held_cnt_q != 6'd0) && (in_ch.in_byte == held_byte_q);
		cnt1  = held_cnt_q + 6'd1;
		a_v   = 1'b0;
		b_v   = 1'b0;
		a_cmd = '{b: held_byte_q, cnt: held_cnt_q, run: 1'b0, fin: 1'b0};
		b_cmd = '{b: in_ch.in_byte, cnt: 6'd1, run: 1'b0, fin: in_ch.in_last};
		cnt_d = held_cnt_q;
		if (match) begin
			a_cmd.cnt = cnt1;
			a_cmd.fin = in_ch.in_last;
			if (cnt1 == rlel_pkg::MAX_RUN) begin
				a_v       = 1'b1;
				a_cmd.run = 1'b1;
				cnt_d     = 6'd0;
			end else if (in_ch.in_last) begin
				// a run of three at the end goes out as singles
				a_v       = 1'b1;
				a_cmd.run = (cnt1 >= 6'd4);
				cnt_d     = 6'd0;
			end else begin
				cnt_d = cnt1;
			end
		end else begin
			a_v       = (held_cnt_q != 6'd0);
			a_cmd.run = (held_cnt_q >= 6'd3);
			b_v       = in_ch.in_last;
			cnt_d     = in_ch.in_last ? 6'd0 : 6'd1;
		end
	end

	always_comb begin
		push     = 1'b0;
		push_cmd = a_cmd;
		priority if (pend_v_q) begin
			push     = !full;
			push_cmd = pend_q;
		end else if (accept) begin
			push     = a_v || b_v;
			push_cmd = a_v ? a_cmd : b_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q <= '0;
			held_cnt_q  <= '0;
			pend_v_q    <= 1'b0;
		end else begin
			if (accept) begin
				held_cnt_q <= cnt_d;
				if (!match) begin
					held_byte_q <= in_ch.in_byte;
				end
			end
			if (pend_v_q && !full) begin
				pend_v_q <= 1'b0;
			end else if (accept && a_v && b_v) begin
				pend_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && a_v && b_v) begin
			pend_q <= b_cmd;
		end
	end

	`RLEL_ASSERT_IMPLY(a_pend_blocks_input, clk, arst_n, pend_v_q, !in_ch.ready, "input taken while a second command waits")
	`RLEL_ASSERT_NEXT(a_run_never_full, clk, arst_n, accept && !in_ch.in_last, held_cnt_q != rlel_pkg::MAX_RUN, "held run reached its limit without being sent")

endmodule

FILE: src/rlel_cmd_fifo.sv
// short command queue between front and back
// depends on rlel_pkg and the assertion macro header
`include "run_length_escape_line_encoder_macros.svh"

module rlel_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rlel_pkg::cmd_t  push_cmd,
	input  logic            pop,
	output logic            full,
	output logic            head_v,
	output rlel_pkg::cmd_t  head
);

	rlel_pkg::cmd_t                 mem [rlel_pkg::FIFO_DEPTH];
	logic [rlel_pkg::FIFO_AW-1:0]   wr_q;
	logic [rlel_pkg::FIFO_AW-1:0]   rd_q;
	logic [rlel_pkg::FIFO_AW:0]     cnt_q;

	assign full   = (cnt_q == (rlel_pkg::FIFO_AW + 1)'(rlel_pkg::FIFO_DEPTH));
	assign head_v = (cnt_q != '0);
	assign head   = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_cmd;
		end
	end

	`RLEL_ASSERT_IMPLY(a_no_overflow, clk, arst_n, full, !push || pop, "command queue overflow")
	`RLEL_ASSERT_IMPLY(a_no_underflow, clk, arst_n, pop, head_v, "pop from empty command queue")

endmodule

FILE: src/rlel_back.sv
// back end: expands queued commands into line-safe bytes, one byte per cycle unless
// stalled, and keeps line length; needs rlel_pkg, rlel_out_if and the macro header
`include "run_length_escape_line_encoder_macros.svh"

module rlel_back (
	input  logic            clk,
	input  logic            arst_n,
	input  rlel_pkg::cfg_t  cfg,
	input  logic            head_v,
	input  rlel_pkg::cmd_t  head,
	output logic            pop,
	rlel_out_if.source      out_ch
);

	localparam logic [2:0] P_UNIT = 3'd0;
	localparam logic [2:0] P_MARK = 3'd1;
	localparam logic [2:0] P_CNT  = 3'd2;
	localparam logic [2:0] P_BYTE = 3'd3;
	localparam logic [2:0] P_CODE = 3'd4;
	localparam logic [2:0] P_END  = 3'd5;

	logic [2:0] ph_q;
	logic [1:0] done_q;
	logic [6:0] len_q;
	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic       adv;
	logic       fire;
	logic       cr_need;
	logic [2:0] eff;
	logic       unit_done;
	logic [7:0] byte_d;
	logic       last_d;
	logic [6:0] len_d;
	logic [2:0] ph_d;
	logic [1:0] done_d;
	logic       pop_d;

	assign adv  = !out_v_q || out_ch.ready;
	assign fire = adv && head_v;
	assign pop  = fire && pop_d;

	assign out_ch.valid    = out_v_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.out_last = out_last_q;

	always_comb begin
		cr_need = !cfg.buffered && (len_q >= cfg.line_limit);
		eff     = ph_q;
		// no line break due: go straight to the unit's first byte
		if (ph_q == P_UNIT && !cr_need) begin
			eff = head.run ? P_MARK : P_BYTE;
		end
		unit_done = 1'b0;
		byte_d    = rlel_pkg::CR_BYTE;
		last_d    = 1'b0;
		len_d     = len_q;
		ph_d      = ph_q;
		done_d    = done_q;
		pop_d     = 1'b0;
		unique case (eff)
			P_UNIT: begin
				len_d = '0;
				ph_d  = head.run ? P_MARK : P_BYTE;
			end
			P_MARK: begin
				byte_d = cfg.marker;
				ph_d   = P_CNT;
			end
			P_CNT: begin
				byte_d = rlel_pkg::six_code(head.cnt);
				ph_d   = P_BYTE;
			end
			P_BYTE: begin
				if (rlel_pkg::is_plain(head.b, cfg.marker)) begin
					byte_d    = head.b;
					len_d     = rlel_pkg::len_add(len_q, 2'd1);
					unit_done = 1'b1;
				end else begin
					byte_d = rlel_pkg::PREFIX_TAB[head.b[7:6]];
					ph_d   = P_CODE;
				end
			end
			P_CODE: begin
				byte_d    = rlel_pkg::six_code(head.b[5:0]);
				len_d     = rlel_pkg::len_add(len_q, 2'd2);
				unit_done = 1'b1;
			end
			P_END: begin
				last_d = 1'b1;
				len_d  = '0;
				ph_d   = P_UNIT;
				done_d = '0;
				pop_d  = 1'b1;
			end
			default: begin
				ph_d = P_UNIT;
			end
		endcase
		if (unit_done) begin
			priority if (!head.run && ((6'(done_q) + 6'd1) < head.cnt)) begin
				done_d = done_q + 2'd1;
				ph_d   = P_UNIT;
			end else if (head.fin && !cfg.buffered) begin
				ph_d = P_END;
			end else begin
				ph_d   = P_UNIT;
				done_d = '0;
				pop_d  = 1'b1;
				if (head.fin) begin
					last_d = 1'b1;
					len_d  = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= P_UNIT;
			done_q  <= '0;
			len_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (adv) begin
				out_v_q <= head_v;
			end
			if (fire) begin
				ph_q   <= ph_d;
				done_q <= done_d;
				len_q  <= len_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= byte_d;
			out_last_q <= last_d;
		end
	end

	`RLEL_ASSERT_IMPLY(a_end_cr_only_on_fin, clk, arst_n, fire && ph_q == P_END, head.fin && !cfg.buffered, "closing line break outside a message end")
	`RLEL_ASSERT_IMPLY(a_count_only_in_run, clk, arst_n, fire && (ph_q == P_CNT || ph_q == P_MARK), head.run, "run marker or count for a single byte")

endmodule

FILE: src/run_length_escape_line_encoder.sv
// channel   | dir | payload            | beat
// in_ch     | in  | in_byte, in_last   | valid && ready
// out_ch    | out | out_byte, out_last | valid && ready
// cfg       | in  | cfg_idx, cfg_data  | cfg_we
// one encoded byte leaves per cycle unless out_ch stalls or the queue is empty; a beat
// closing a held group and a message at once queues two commands; input waits for both
// each input beat yields 0 to 10 output bytes, so the output side sets the pace
// a four-entry command queue lets the front keep taking beats while bytes drain
// reset clears run state, line length, queue and registers; no clearing pass
//
// top level: configuration registers, front end, command queue and back end
// depends on rlel_pkg, rlel_in_if, rlel_out_if, rlel_front, rlel_cmd_fifo, rlel_back
module run_length_escape_line_encoder (
	input  logic        clk,
	input  logic        arst_n,
	rlel_in_if.sink     in_ch,
	rlel_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [7:0]  cfg_data
);

	rlel_pkg::cfg_t cfg_q;
	logic           full;
	logic           push;
	rlel_pkg::cmd_t push_cmd;
	logic           pop;
	logic           head_v;
	rlel_pkg::cmd_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffered   <= 1'b0;
			cfg_q.line_limit <= rlel_pkg::LIMIT_RESET;
			cfg_q.marker     <= rlel_pkg::MARKER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				rlel_pkg::CFG_BUFFERED: cfg_q.buffered   <= cfg_data[0];
				rlel_pkg::CFG_LIMIT:    cfg_q.line_limit <= cfg_data[6:0];
				rlel_pkg::CFG_MARKER:   cfg_q.marker     <= cfg_data;
				default:                cfg_q            <= cfg_q;
			endcase
		end
	end

	rlel_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	rlel_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (full),
		.head_v   (head_v),
		.head     (head)
	);

	rlel_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head_v (head_v),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule
